// File: hw/rtl/pvcd_pkg.sv
// Shared types, register indexes and constants of the capture decoder.
package pvcd_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BLACK_LEVEL        = 3'd0,
        REG_GAIN               = 3'd1,
        REG_LINE_VALID_COLUMNS = 3'd2,
        REG_FRAME_VALID_ROWS   = 3'd3,
        REG_MAX_COLUMNS        = 3'd4,
        REG_MAX_ROWS           = 3'd5
    } cfg_reg_t;

    // Register widths
    localparam int BLACK_W     = 8;
    localparam int GAIN_W      = 10;
    localparam int LINE_VAL_W  = 11;
    localparam int FRAME_VAL_W = 10;
    localparam int MAX_COL_W   = 12;
    localparam int MAX_ROW_W   = 11;

    // Register reset values
    localparam logic [BLACK_W-1:0]     BLACK_RST     = 8'd76;
    localparam logic [GAIN_W-1:0]      GAIN_RST      = 10'd440;
    localparam logic [LINE_VAL_W-1:0]  LINE_VAL_RST  = 11'd600;
    localparam logic [FRAME_VAL_W-1:0] FRAME_VAL_RST = 10'd200;
    localparam logic [MAX_COL_W-1:0]   MAX_COL_RST   = 12'd1440;
    localparam logic [MAX_ROW_W-1:0]   MAX_ROW_RST   = 11'd720;

    // Capture word layout
    localparam int WORD_W    = 16;
    localparam int HSYNC_BIT = 12;
    localparam int VSYNC_BIT = 13;
    localparam int SUM_W     = 6;
    localparam int FRAME_W   = 16;
    localparam int PIX_W     = 8;

    // Width for position compares, wide enough for any parameter value plus one.
    localparam int CMP_W = 17;

    // Products of the scale stage
    localparam int PROD_Y_W = 21;
    localparam int PROD_C_W = 19;

    localparam logic signed [13:0] CHROMA_ZERO = 14'sd128;
    localparam logic signed [13:0] PIX_MAX     = 14'sd255;

    function automatic logic [PIX_W-1:0] clamp_u8(input logic signed [13:0] x);
        logic [PIX_W-1:0] res;
        if (x < 14'sd0) begin
            res = '0;
        end else if (x > PIX_MAX) begin
            res = '1;
        end else begin
            res = x[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/pcm_video_capture_decoder.sv
// Capture word decoder: sync tracking, 4-word pixel grouping, YUV scaling and clamping.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------------
//  s_      | in  | s_valid / s_ready  | s_sample_word
//  m_      | out | m_valid / m_ready  | m_luma, m_chroma_u, m_chroma_v, m_column,
//          |     |                    | m_row, m_frame_number
//  cfg_    | in  | cfg_wr_en          | cfg_index, cfg_wdata
//
// One capture word is taken per cycle while s_ready is high. Counters and channel sums
// update at the input beat; a finished group then passes a sum register, a multiply
// register and the output register before the pixel appears on the output.
// Reset (aresetn low at a clock edge) clears the group, the positions, the frame count and
// loads the register defaults. A stall on m_ready holds each stage only when the stage
// after it is full, so the input keeps flowing until all three stages hold pixels.
module pcm_video_capture_decoder #(
    parameter int COLUMN_BITS = 11,
    parameter int ROW_BITS    = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [pvcd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pvcd_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pvcd_pkg::WORD_W-1:0]         s_sample_word,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pvcd_pkg::PIX_W-1:0]          m_luma,
    output logic [pvcd_pkg::PIX_W-1:0]          m_chroma_u,
    output logic [pvcd_pkg::PIX_W-1:0]          m_chroma_v,
    output logic [COLUMN_BITS-1:0]              m_column,
    output logic [ROW_BITS-1:0]                 m_row,
    output logic [pvcd_pkg::FRAME_W-1:0]        m_frame_number
);
    import pvcd_pkg::*;

    localparam logic [CMP_W-1:0] COL_FULL = CMP_W'(1) << COLUMN_BITS;
    localparam logic [CMP_W-1:0] ROW_FULL = CMP_W'(1) << ROW_BITS;

    // Configuration registers
    logic [BLACK_W-1:0]     black_reg;
    logic [GAIN_W-1:0]      gain_reg;
    logic [LINE_VAL_W-1:0]  line_val_reg;
    logic [FRAME_VAL_W-1:0] frame_val_reg;
    logic [MAX_COL_W-1:0]   max_col_reg;
    logic [MAX_ROW_W-1:0]   max_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            black_reg     <= BLACK_RST;
            gain_reg      <= GAIN_RST;
            line_val_reg  <= LINE_VAL_RST;
            frame_val_reg <= FRAME_VAL_RST;
            max_col_reg   <= MAX_COL_RST;
            max_row_reg   <= MAX_ROW_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BLACK_LEVEL:        black_reg     <= cfg_wdata[BLACK_W-1:0];
                REG_GAIN:               gain_reg      <= cfg_wdata[GAIN_W-1:0];
                REG_LINE_VALID_COLUMNS: line_val_reg  <= cfg_wdata[LINE_VAL_W-1:0];
                REG_FRAME_VALID_ROWS:   frame_val_reg <= cfg_wdata[FRAME_VAL_W-1:0];
                REG_MAX_COLUMNS:        max_col_reg   <= cfg_wdata[MAX_COL_W-1:0];
                REG_MAX_ROWS:           max_row_reg   <= cfg_wdata[MAX_ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective limits: zero or anything above the counter range means the full range.
    logic [CMP_W-1:0] col_limit;
    logic [CMP_W-1:0] row_limit;

    always_comb begin
        col_limit = CMP_W'(max_col_reg);
        if (max_col_reg == '0 || CMP_W'(max_col_reg) > COL_FULL) begin
            col_limit = COL_FULL;
        end
        row_limit = CMP_W'(max_row_reg);
        if (max_row_reg == '0 || CMP_W'(max_row_reg) > ROW_FULL) begin
            row_limit = ROW_FULL;
        end
    end

    // Pipeline enables
    logic out_en;
    logic q_en;
    logic p_en;
    logic in_beat;

    logic p_vld_reg;
    logic q_vld_reg;
    logic m_valid_reg;

    assign out_en  = !m_valid_reg || m_ready;
    assign q_en    = !q_vld_reg || out_en;
    assign p_en    = !p_vld_reg || q_en;
    assign s_ready = p_en;
    assign in_beat = s_valid && s_ready;

    // Group and position state
    logic [1:0]             phase_reg, phase_next;
    logic [SUM_W-1:0]       red_reg, red_next;
    logic [SUM_W-1:0]       green_reg, green_next;
    logic [SUM_W-1:0]       blue_reg, blue_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic [FRAME_W-1:0]     frame_reg, frame_next;

    logic             hsync;
    logic             vsync;
    logic             sync_word;
    logic             pix_done;
    logic [SUM_W-1:0] red_acc;
    logic [SUM_W-1:0] green_acc;
    logic [SUM_W-1:0] blue_acc;
    logic [CMP_W-1:0] col_inc;
    logic [CMP_W-1:0] row_inc;
    logic [CMP_W-1:0] row_adv;

    assign hsync     = !s_sample_word[HSYNC_BIT];
    assign vsync     = !s_sample_word[VSYNC_BIT];
    assign sync_word = (phase_reg == 2'd0) && (hsync || vsync);
    assign pix_done  = !sync_word && (phase_reg == 2'd3);
    assign red_acc   = red_reg + SUM_W'(s_sample_word[11:8]);
    assign green_acc = green_reg + SUM_W'(s_sample_word[7:4]);
    assign blue_acc  = blue_reg + SUM_W'(s_sample_word[3:0]);
    assign col_inc   = CMP_W'(col_reg) + CMP_W'(1);
    assign row_inc   = CMP_W'(row_reg) + CMP_W'(1);

    always_comb begin
        phase_next = phase_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        frame_next = frame_reg;
        row_adv    = CMP_W'(row_reg);
        if (in_beat) begin
            if (sync_word) begin
                col_next = '0;
                if (vsync) begin
                    // Vertical sync wins when both flags are low.
                    if (CMP_W'(row_reg) > CMP_W'(frame_val_reg)) begin
                        frame_next = frame_reg + FRAME_W'(1);
                    end
                    row_next = '0;
                end else if (CMP_W'(col_reg) > CMP_W'(line_val_reg)) begin
                    row_next = (row_inc >= row_limit) ? '0 : ROW_BITS'(row_inc);
                end
            end else begin
                phase_next = phase_reg + 2'd1;
                if (pix_done) begin
                    red_next   = '0;
                    green_next = '0;
                    blue_next  = '0;
                    if (col_inc >= col_limit) begin
                        col_next = '0;
                        row_adv  = row_inc;
                    end else begin
                        col_next = COLUMN_BITS'(col_inc);
                    end
                    // Also pulls back a row left beyond a newly lowered limit.
                    row_next = (row_adv >= row_limit) ? '0 : ROW_BITS'(row_adv);
                end else begin
                    red_next   = red_acc;
                    green_next = green_acc;
                    blue_next  = blue_acc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            frame_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            frame_reg <= frame_next;
        end
    end

    // Stage P: completed channel sums with the pixel position
    logic [SUM_W-1:0]       p_red_reg;
    logic [SUM_W-1:0]       p_green_reg;
    logic [SUM_W-1:0]       p_blue_reg;
    logic [COLUMN_BITS-1:0] p_col_reg;
    logic [ROW_BITS-1:0]    p_row_reg;
    logic [FRAME_W-1:0]     p_frame_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
        end else if (p_en) begin
            p_vld_reg <= s_valid && pix_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_en && s_valid && pix_done) begin
            p_red_reg   <= red_acc;
            p_green_reg <= green_acc;
            p_blue_reg  <= blue_acc;
            p_col_reg   <= col_reg;
            p_row_reg   <= row_reg;
            p_frame_reg <= frame_reg;
        end
    end

    // Stage Q: black-corrected luma and color differences scaled by gain. With the sums scaled by four the
    // divisions are exact: Y = 2G+R+B, U-128 = 2(B-G), V-128 = 2(R-G) in sum units.
    logic [PIX_W-1:0]          y_lvl;
    logic signed [9:0]         y_diff;
    logic signed [SUM_W:0]     bg_diff;
    logic signed [SUM_W:0]     rg_diff;
    logic signed [SUM_W+1:0]   u_diff;
    logic signed [SUM_W+1:0]   v_diff;
    logic signed [GAIN_W:0]    gain_s;
    logic signed [PROD_Y_W-1:0] prod_y;
    logic signed [PROD_C_W-1:0] prod_u;
    logic signed [PROD_C_W-1:0] prod_v;

    assign y_lvl   = {1'b0, p_green_reg, 1'b0} + PIX_W'(p_red_reg) + PIX_W'(p_blue_reg);
    assign y_diff  = $signed({2'b00, y_lvl}) - $signed({2'b00, black_reg});
    assign bg_diff = $signed({1'b0, p_blue_reg}) - $signed({1'b0, p_green_reg});
    assign rg_diff = $signed({1'b0, p_red_reg}) - $signed({1'b0, p_green_reg});
    assign u_diff  = {bg_diff, 1'b0};
    assign v_diff  = {rg_diff, 1'b0};
    assign gain_s  = $signed({1'b0, gain_reg});
    assign prod_y  = y_diff * gain_s;
    assign prod_u  = u_diff * gain_s;
    assign prod_v  = v_diff * gain_s;

    logic signed [PROD_Y_W-1:0] q_prod_y_reg;
    logic signed [PROD_C_W-1:0] q_prod_u_reg;
    logic signed [PROD_C_W-1:0] q_prod_v_reg;
    logic [COLUMN_BITS-1:0]     q_col_reg;
    logic [ROW_BITS-1:0]        q_row_reg;
    logic [FRAME_W-1:0]         q_frame_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_vld_reg <= 1'b0;
        end else if (q_en) begin
            q_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_en && p_vld_reg) begin
            q_prod_y_reg <= prod_y;
            q_prod_u_reg <= prod_u;
            q_prod_v_reg <= prod_v;
            q_col_reg    <= p_col_reg;
            q_row_reg    <= p_row_reg;
            q_frame_reg  <= p_frame_reg;
        end
    end

    // Output stage: flooring shift by eight, chroma offset, clamp.
    logic signed [PROD_Y_W-9:0] y_shift;
    logic signed [PROD_C_W-9:0] u_shift;
    logic signed [PROD_C_W-9:0] v_shift;
    logic [PIX_W-1:0]           luma_next;
    logic [PIX_W-1:0]           cu_next;
    logic [PIX_W-1:0]           cv_next;

    assign y_shift   = q_prod_y_reg[PROD_Y_W-1:8];
    assign u_shift   = q_prod_u_reg[PROD_C_W-1:8];
    assign v_shift   = q_prod_v_reg[PROD_C_W-1:8];
    assign luma_next = clamp_u8(14'(y_shift));
    assign cu_next   = clamp_u8(14'(u_shift) + CHROMA_ZERO);
    assign cv_next   = clamp_u8(14'(v_shift) + CHROMA_ZERO);

    logic [PIX_W-1:0]       m_luma_reg;
    logic [PIX_W-1:0]       m_cu_reg;
    logic [PIX_W-1:0]       m_cv_reg;
    logic [COLUMN_BITS-1:0] m_col_reg;
    logic [ROW_BITS-1:0]    m_row_reg;
    logic [FRAME_W-1:0]     m_frame_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= q_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en && q_vld_reg) begin
            m_luma_reg  <= luma_next;
            m_cu_reg    <= cu_next;
            m_cv_reg    <= cv_next;
            m_col_reg   <= q_col_reg;
            m_row_reg   <= q_row_reg;
            m_frame_reg <= q_frame_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_luma         = m_luma_reg;
    assign m_chroma_u     = m_cu_reg;
    assign m_chroma_v     = m_cv_reg;
    assign m_column       = m_col_reg;
    assign m_row          = m_row_reg;
    assign m_frame_number = m_frame_reg;

    // A sync word at the start of a group always restarts the line.
    a_sync_clears_column: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat && sync_word |=> col_reg == '0)
        else $error("sync beat did not clear the column");

    // Sync words leave the group phase alone; every other beat advances it.
    a_phase_step: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat && !sync_word |=> phase_reg == $past(phase_reg) + 2'd1)
        else $error("group phase did not advance on a data beat");

    // A new pixel enters the sum stage only from the fourth word of a group.
    a_pixel_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(p_vld_reg) |-> $past(in_beat && phase_reg == 2'd3))
        else $error("pixel stage loaded without a completed group");

    // A product waiting behind a full output register is kept.
    a_q_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        q_vld_reg && !out_en |=> q_vld_reg && $stable(q_prod_y_reg) && $stable(q_col_reg))
        else $error("multiply stage lost a pixel under stall");

endmodule
